// ----- hw/rtl/telnet_iac_deframer_core_macros.svh -----
// Assertion macros shared by the Telnet IAC deframer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TELNET_IAC_DEFRAMER_CORE_MACROS_SVH
`define TELNET_IAC_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, checked on clock, off during reset
`define TID_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on clock, off during reset
`define TID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tid_pkg.sv -----
// Types and constants of the Telnet IAC deframer.
// No dependencies; used by all tid_* modules and the top level.
package tid_pkg;

   localparam logic [7:0] TN_IAC  = 8'hFF;
   localparam logic [7:0] TN_DONT = 8'hFE;
   localparam logic [7:0] TN_DO   = 8'hFD;
   localparam logic [7:0] TN_WONT = 8'hFC;
   localparam logic [7:0] TN_WILL = 8'hFB;
   localparam logic [7:0] TN_SB   = 8'hFA;
   localparam logic [7:0] TN_SE   = 8'hF0;
   localparam logic [7:0] TN_EOR  = 8'hEF;

   localparam logic [2:0] EV_DATA   = 3'd0;
   localparam logic [2:0] EV_REC    = 3'd1;
   localparam logic [2:0] EV_OPT    = 3'd2;
   localparam logic [2:0] EV_SBBYTE = 3'd3;
   localparam logic [2:0] EV_SBEND  = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] command;
      logic [7:0] value;
   } event_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } in_item_type;

endpackage

// ----- hw/rtl/tid_in_stage.sv -----
// Input register of the Telnet IAC deframer: holds one received byte.
// Depends on tid_pkg.
module tid_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_data,
   input  logic                consume,
   output tid_pkg::in_item_type item
);
   import tid_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;

   assign in_ready = !valid_ff || consume;
   assign valid_in = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

// ----- hw/rtl/tid_parser.sv -----
// IAC state machine of the Telnet IAC deframer: classifies one byte per cycle unless an event is held up.
// Depends on tid_pkg and telnet_iac_deframer_core_macros.svh.
`include "telnet_iac_deframer_core_macros.svh"
module tid_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  tid_pkg::in_item_type item,
   input  logic                 out_ready,
   output logic                 consume,
   output logic                 ev_load,
   output tid_pkg::event_type   ev
);
   import tid_pkg::*;

   typedef enum logic [2:0] {
      ST_NORMAL, ST_IAC, ST_WILL, ST_WONT, ST_DO, ST_DONT, ST_SB, ST_SB_IAC
   } state_type;

   state_type  state_ff, state_in;
   logic       rec_ff, rec_in;
   logic       has_ev;
   logic [2:0] cmd_diff;
   logic [7:0] b;

   assign b        = item.data;
   assign cmd_diff = state_ff - ST_WILL;

   always_comb begin
      state_in   = state_ff;
      rec_in     = rec_ff;
      has_ev     = 1'b0;
      ev.kind    = EV_DATA;
      ev.command = 2'd0;
      ev.value   = 8'd0;
      unique case (state_ff)
         ST_NORMAL: begin
            if (b == TN_IAC) begin
               state_in = ST_IAC;
            end else begin
               rec_in   = 1'b1;
               has_ev   = 1'b1;
               ev.value = b;
            end
         end
         ST_IAC: begin
            state_in = ST_NORMAL;
            priority if (b == TN_IAC) begin
               rec_in   = 1'b1;
               has_ev   = 1'b1;
               ev.value = TN_IAC;
            end else if (b == TN_EOR) begin
               if (rec_ff) begin
                  rec_in  = 1'b0;
                  has_ev  = 1'b1;
                  ev.kind = EV_REC;
               end
            end else if (b == TN_WILL) begin
               state_in = ST_WILL;
            end else if (b == TN_WONT) begin
               state_in = ST_WONT;
            end else if (b == TN_DO) begin
               state_in = ST_DO;
            end else if (b == TN_DONT) begin
               state_in = ST_DONT;
            end else if (b == TN_SB) begin
               state_in = ST_SB;
            end else begin
               state_in = ST_NORMAL;
            end
         end
         ST_WILL, ST_WONT, ST_DO, ST_DONT: begin
            state_in   = ST_NORMAL;
            has_ev     = 1'b1;
            ev.kind    = EV_OPT;
            ev.command = cmd_diff[1:0];
            ev.value   = b;
         end
         ST_SB: begin
            if (b == TN_IAC) begin
               state_in = ST_SB_IAC;
            end else begin
               has_ev   = 1'b1;
               ev.kind  = EV_SBBYTE;
               ev.value = b;
            end
         end
         ST_SB_IAC: begin
            if (b == TN_SE) begin
               state_in = ST_NORMAL;
               has_ev   = 1'b1;
               ev.kind  = EV_SBEND;
            end else begin
               state_in = ST_SB;
               if (b == TN_IAC) begin
                  has_ev   = 1'b1;
                  ev.kind  = EV_SBBYTE;
                  ev.value = TN_IAC;
               end
            end
         end
      endcase
   end

   // an item that yields nothing never waits on the output side
   assign consume = item.valid && (!has_ev || out_ready);
   assign ev_load = consume && has_ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NORMAL;
         rec_ff   <= 1'b0;
      end else if (consume) begin
         state_ff <= state_in;
         rec_ff   <= rec_in;
      end
   end

   `TID_ASSERT_IMPL(a_rec_needs_data, ev_load && ev.kind == EV_REC, rec_ff,
      "record end without record data")
   `TID_ASSERT_IMPL(a_opt_from_pending,
      ev_load && ev.kind == EV_OPT,
      state_ff == ST_WILL || state_ff == ST_WONT || state_ff == ST_DO || state_ff == ST_DONT,
      "option event outside a pending option state")
   `TID_ASSERT_NEXT(a_sbiac_returns,
      consume && state_ff == ST_SB_IAC && b != TN_SE, state_ff == ST_SB,
      "IAC in subnegotiation did not return to subnegotiation")
   `TID_ASSERT_NEXT(a_data_sets_rec, ev_load && ev.kind == EV_DATA, rec_ff,
      "data byte did not mark the record")

endmodule

// ----- hw/rtl/tid_out_stage.sv -----
// Result register of the Telnet IAC deframer: holds one event until taken.
// Depends on tid_pkg.
module tid_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  tid_pkg::event_type ev,
   output logic               free,
   output logic               out_valid,
   input  logic               out_ready,
   output tid_pkg::event_type out_ev
);
   import tid_pkg::*;

   logic      valid_ff, valid_in;
   event_type ev_ff;

   assign free     = !valid_ff || out_ready;
   assign valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         ev_ff <= ev;
      end
   end

   assign out_valid = valid_ff;
   assign out_ev    = ev_ff;

endmodule

// ----- hw/rtl/telnet_iac_deframer_core.sv -----
// Telnet IAC deframer, top level.
// Depends on tid_pkg, tid_in_stage, tid_parser and tid_out_stage.
//
// Usage:
//   req_* carries received Telnet bytes, one item per byte (tdata[7:0]).
//   rsp_* carries classified events: rsp_tuser is the event kind
//   (data byte, record end, option command, subneg byte, subneg end),
//   rsp_tdata holds the option command and the byte value.
//   Bytes that only move the IAC state machine (IAC, WILL/WONT/DO/DONT prefix, SB,
//   NOP, empty EOR, stray IAC in subnegotiation) produce no event.
// Timing:
//   One byte per cycle sustained while rsp_tready is high. A byte sits in
//   the input register, the state machine decodes it and its event is
//   registered in the result register, from which it is driven on rsp_*.
//   The combinational decode between the two registers sets the rate.
// Reset:
//   Synchronous, active high; parser returns to normal data, the record
//   flag clears, both registers empty.
// Stall:
//   With rsp_tready low the result register holds its event; one more
//   byte waits in the input register, then req_tready drops. Bytes that
//   produce no event keep flowing while an event waits.
module telnet_iac_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] command, [9:2] value, [15:10] zero
   output logic [2:0]  rsp_tuser    // [2:0] event_kind
);
   import tid_pkg::*;

   in_item_type item;
   event_type   ev, out_ev;
   logic        consume, ev_load, out_free;

   tid_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .consume  (consume),
      .item     (item)
   );

   tid_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .out_ready (out_free),
      .consume   (consume),
      .ev_load   (ev_load),
      .ev        (ev)
   );

   tid_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (ev_load),
      .ev        (ev),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ev    (out_ev)
   );

   assign rsp_tdata = {6'd0, out_ev.value, out_ev.command};
   assign rsp_tuser = out_ev.kind;

endmodule
